>>> rtl/chrl_pkg.sv
// Shared types and constants for the consistent-hash ring lookup block.
// No dependencies; imported by consistent_hash_ring_lookup and chrl_fold.
package chrl_pkg;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  // FNV-1a 64 prime is 2^40 + 0x1b3
  localparam int          FNV_SHIFT    = 40;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;

  typedef enum logic [1:0] {
    OP_SERVER = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ADDED = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FOLD,
    S_FIN,
    S_INS,
    S_ICMP,
    S_SRCH,
    S_SCMP,
    S_LKRD,
    S_PUT
  } state_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [3:0]  owner;
  } ring_entry_t;

endpackage

>>> rtl/consistent_hash_ring_lookup.sv
// Consistent-hash ring: builds a sorted ring of FNV-1a 64 points and looks keys up.
// Input channel (in_*): one key byte per beat with opcode, presence and last flags.
//   Opcode 0 adds a server, 1 looks a key up, 2 clears the ring, 3 is dropped.
// Result channel (out_*): one beat per completed key (server index, status, hash).
// Flow: a present byte passes through the fold state; an absent one skips it. A completed
//   key is then finalised on the single shared fold unit. A lookup then runs a binary
//   search over the table RAM, each step a read and a compare, and then reads the
//   owner. Adding a server finalises and inserts VNODES points, each placed by an
//   insertion scan that moves larger entries up one place through the RAM port; a point
//   that lands in slot 0 needs no compare. Every result is then loaded into the output
//   register.
// in_ready is high only while the sequencer is idle.
// Reset clears the point count, server count and running hash; the table RAM
//   is not cleared, as only entries below the point count are ever read.
// A stalled receiver holds the result in the output register; the next key may
//   still stream in and finishes up to its result, which waits for the register.
module consistent_hash_ring_lookup import chrl_pkg::*; #(
  parameter int MAX_SERVERS = 16,
  parameter int VNODES      = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_server_index,
  output logic [1:0]  out_status,
  output logic [63:0] out_key_hash
);

  localparam int DEPTH = MAX_SERVERS * VNODES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(MAX_SERVERS + 1);
  localparam int VW    = (VNODES > 1) ? $clog2(VNODES) : 1;
  localparam int EW    = $bits(ring_entry_t);

  state_t state_r, state_nxt;

  logic [63:0]   run_r, run_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [63:0]   base_r, base_nxt;
  logic [63:0]   hv_r, hv_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [2:0]    k_r, k_nxt;
  logic          phase_r, phase_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] srv_r, srv_nxt;
  logic [VW-1:0] vn_r, vn_nxt;
  logic [CW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [3:0]    res_idx_r, res_idx_nxt;
  logic [1:0]    res_st_r, res_st_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_idx_r, out_idx_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [63:0]   out_hash_r, out_hash_nxt;

  logic [63:0]   fold_acc, fold_res;
  logic [7:0]    fold_byte;
  logic          in_fire, fin_last, ring_full, put_ok;
  logic [CW:0]   mid_sum;
  logic [3:0]    owner;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  ring_entry_t   ram_wdata, ram_rdata;
  logic [EW-1:0] ram_rbits;

  // shared fold unit operand select
  assign fold_acc  = (state_r == S_FOLD) ? run_r : acc_r;
  assign fold_byte = (state_r == S_FOLD) ? byte_r : base_r[8*k_r +: 8];

  chrl_fold u_fold (
    .acc_i  (fold_acc),
    .byte_i (fold_byte),
    .acc_o  (fold_res)
  );

  chrl_ram #(.WIDTH(EW), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );
  assign ram_rdata = ring_entry_t'(ram_rbits);

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign fin_last  = (k_r == 3'd7);
  assign ring_full = (srv_r >= SW'(MAX_SERVERS)) || (count_r > CW'(DEPTH - VNODES));
  assign put_ok    = !out_valid_r || out_ready;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign owner     = 4'(srv_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_opcode == OP_SERVER || in_opcode == OP_LOOKUP)) begin
          if (in_byte_present) begin
            state_nxt = S_FOLD;
          end else if (in_last_byte) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FOLD: state_nxt = last_r ? S_FIN : S_IDLE;
      S_FIN: begin
        if (fin_last) begin
          if (phase_r) begin
            state_nxt = S_INS;
          end else if (op_r == OP_SERVER) begin
            state_nxt = ring_full ? S_PUT : S_FIN;
          end else begin
            state_nxt = (count_r == '0) ? S_PUT : S_SRCH;
          end
        end
      end
      S_INS: begin
        if (slot_r == '0) begin
          state_nxt = (vn_r == VW'(VNODES - 1)) ? S_PUT : S_FIN;
        end else begin
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        if (ram_rdata.hash > hv_r) begin
          state_nxt = S_INS;
        end else begin
          state_nxt = (vn_r == VW'(VNODES - 1)) ? S_PUT : S_FIN;
        end
      end
      S_SRCH: state_nxt = (lo_r < hi_r) ? S_SCMP : S_LKRD;
      S_SCMP: state_nxt = S_SRCH;
      S_LKRD: state_nxt = S_PUT;
      S_PUT:  state_nxt = put_ok ? S_IDLE : S_PUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    run_nxt       = run_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    hv_nxt        = hv_r;
    key_nxt       = key_r;
    k_nxt         = k_r;
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    srv_nxt       = srv_r;
    vn_nxt        = vn_r;
    slot_nxt      = slot_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_idx_nxt   = res_idx_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    out_hash_nxt  = out_hash_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_r[AW-1:0];
    ram_wdata     = '{hash: hv_r, owner: owner};
    ram_raddr     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_opcode;
          byte_nxt = in_data_byte;
          last_nxt = in_last_byte;
          if (in_opcode == OP_CLEAR) begin
            count_nxt = '0;
            srv_nxt   = '0;
            run_nxt   = FNV_BASIS;
          end else if (in_opcode != OP_NONE && !in_byte_present && in_last_byte) begin
            acc_nxt   = run_r;
            base_nxt  = run_r;
            k_nxt     = '0;
            phase_nxt = 1'b0;
            run_nxt   = FNV_BASIS;
          end
        end
      end
      S_FOLD: begin
        if (last_r) begin
          acc_nxt   = fold_res;
          base_nxt  = fold_res;
          k_nxt     = '0;
          phase_nxt = 1'b0;
          run_nxt   = FNV_BASIS;
        end else begin
          run_nxt = fold_res;
        end
      end
      S_FIN: begin
        acc_nxt = fold_res;
        k_nxt   = k_r + 3'd1;
        if (fin_last) begin
          if (phase_r) begin
            // new ring point; it also seeds the next one
            hv_nxt   = fold_res;
            base_nxt = fold_res;
            slot_nxt = count_r;
          end else begin
            key_nxt = fold_res;
            if (op_r == OP_SERVER) begin
              if (ring_full) begin
                res_idx_nxt = '0;
                res_st_nxt  = ST_FULL;
              end else begin
                base_nxt  = fold_res;
                phase_nxt = 1'b1;
                vn_nxt    = '0;
              end
            end else if (count_r == '0) begin
              res_idx_nxt = '0;
              res_st_nxt  = ST_EMPTY;
            end else begin
              lo_nxt = '0;
              hi_nxt = count_r;
            end
          end
        end
      end
      S_INS: begin
        if (slot_r == '0) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          vn_nxt    = vn_r + VW'(1);
          if (vn_r == VW'(VNODES - 1)) begin
            res_idx_nxt = owner;
            res_st_nxt  = ST_ADDED;
            srv_nxt     = srv_r + SW'(1);
          end
        end else begin
          ram_raddr = AW'(slot_r - CW'(1));
        end
      end
      S_ICMP: begin
        ram_we = 1'b1;
        if (ram_rdata.hash > hv_r) begin
          // shift the larger entry up one place
          ram_wdata = ram_rdata;
          slot_nxt  = slot_r - CW'(1);
        end else begin
          count_nxt = count_r + CW'(1);
          vn_nxt    = vn_r + VW'(1);
          if (vn_r == VW'(VNODES - 1)) begin
            res_idx_nxt = owner;
            res_st_nxt  = ST_ADDED;
            srv_nxt     = srv_r + SW'(1);
          end
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CW:1];
          ram_raddr = AW'(mid_sum[CW:1]);
        end else begin
          ram_raddr = (lo_r >= count_r) ? '0 : AW'(lo_r);
        end
      end
      S_SCMP: begin
        if (ram_rdata.hash < key_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
      end
      S_LKRD: begin
        res_idx_nxt = ram_rdata.owner;
        res_st_nxt  = ST_FOUND;
      end
      S_PUT: begin
        if (put_ok) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_st_nxt    = res_st_r;
          out_hash_nxt  = key_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= FNV_BASIS;
      count_r     <= '0;
      srv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      count_r     <= count_nxt;
      srv_r       <= srv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    hv_r      <= hv_nxt;
    key_r     <= key_nxt;
    k_r       <= k_nxt;
    phase_r   <= phase_nxt;
    op_r      <= op_nxt;
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    vn_r      <= vn_nxt;
    slot_r    <= slot_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    res_idx_r <= res_idx_nxt;
    res_st_r  <= res_st_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_server_index = out_idx_r;
  assign out_status       = out_st_r;
  assign out_key_hash     = out_hash_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("ring point count beyond table depth");

  a_we_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INS || state_r == S_ICMP))
    else $error("table write outside insertion");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_CLEAR) |=> (count_r == '0 && srv_r == '0))
    else $error("clear did not empty the ring");

endmodule

>>> rtl/chrl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module chrl_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/chrl_fold.sv
// Shared FNV-1a 64 fold unit: xor one byte in, multiply by the FNV prime.
// Depends on chrl_pkg.
module chrl_fold import chrl_pkg::*; (
  input  logic [63:0] acc_i,
  input  logic [7:0]  byte_i,
  output logic [63:0] acc_o
);

  logic [63:0] x;
  logic [63:0] prod;

  // prime is 2^40 + small constant: one shift plus a 64 x 9 multiply
  assign x     = acc_i ^ {56'd0, byte_i};
  assign prod  = x * {55'd0, FNV_PRIME_LO};
  assign acc_o = (x << FNV_SHIFT) + prod;

endmodule
